// ===== design/pmid_pkg.sv =====
package pmid_pkg;

    localparam int COORD_W = 24;
    localparam int BOX_W   = 24;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int WRAP_W  = COORD_W + 2;
    localparam int MAG_W   = COORD_W + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int REM_W   = ROOT_W + 1;
    localparam int DIST_W  = 26;

    localparam logic [BOX_W-1:0] BOX_RESET = 24'd655360;

    typedef enum logic [1:0] {
        FUNC_PLAIN  = 2'd0,
        FUNC_BOTH   = 2'd1,
        FUNC_X_ONLY = 2'd2,
        FUNC_ORIGIN = 2'd3
    } func_t;

    // One slot of the square root chain.
    typedef struct packed {
        logic              valid;
        logic [SQ_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sqrt_slot_t;

endpackage

// ===== design/periodic_min_image_distance_top.sv =====
// Minimum-image distance of two 2D points in a periodic square box.
//
// Input channel: in_valid / in_stall with func, first_x, first_y, second_x,
// second_y (signed Q8.16). Output channel: out_valid / out_stall with
// dist_out (unsigned Q10.16, floor of the square root).
// Config channel: cfg_valid / cfg_ready with box_length; cfg_ready is always
// high, write only while no item is in flight.
//
// Throughput: one item per cycle while out_stall does not hold a result.
// Path from transfer in to out_valid: five front stages (difference,
// wrap, magnitude, square, sum), a chain of 25 square root cells retiring
// one root bit each, and the output register.
//
// Reset clears all valid bits and loads box_length with 10.0.
// While out_valid is high and out_stall holds it, the whole pipeline
// freezes and in_stall is raised in the same cycle; the result holds.
module periodic_min_image_distance_top
    import pmid_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [1:0]                func,
    input  logic signed [COORD_W-1:0] first_x,
    input  logic signed [COORD_W-1:0] first_y,
    input  logic signed [COORD_W-1:0] second_x,
    input  logic signed [COORD_W-1:0] second_y,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [DIST_W-1:0]         dist_out,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [BOX_W-1:0]          box_length
);

    logic              advance;
    logic [BOX_W-1:0]  box_reg;
    logic              out_valid_reg;
    logic [DIST_W-1:0] dist_reg;
    sqrt_slot_t        chain [0:ROOT_W];

    assign advance   = !out_valid_reg || !out_stall;
    assign in_stall  = !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            box_reg <= BOX_RESET;
        else if (cfg_valid)
            box_reg <= box_length;
    end

    pmid_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (advance),
        .load       (in_valid),
        .func       (func),
        .first_x    (first_x),
        .first_y    (first_y),
        .second_x   (second_x),
        .second_y   (second_y),
        .box_length (box_reg),
        .slot       (chain[0])
    );

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_cell
        pmid_sqrt_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (advance),
            .slot_in  (chain[i]),
            .slot_out (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= chain[ROOT_W].valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            dist_reg <= DIST_W'(chain[ROOT_W].root);
    end

    assign out_valid = out_valid_reg;
    assign dist_out  = dist_reg;

endmodule

// ===== design/pmid_front.sv =====
module pmid_front
    import pmid_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     load,
    input  logic [1:0]               func,
    input  logic signed [COORD_W-1:0] first_x,
    input  logic signed [COORD_W-1:0] first_y,
    input  logic signed [COORD_W-1:0] second_x,
    input  logic signed [COORD_W-1:0] second_y,
    input  logic [BOX_W-1:0]         box_length,
    output sqrt_slot_t               slot
);

    // Stage valid bits: difference, wrap, magnitude, square, sum.
    logic [4:0] valid_reg;
    logic [4:0] valid_next;

    logic signed [DIFF_W-1:0] dx_reg, dy_reg;
    logic                     wrap_x_reg, wrap_y_reg;
    logic signed [WRAP_W-1:0] wx_reg, wy_reg;
    logic [MAG_W-1:0]         mx_reg, my_reg;
    logic [SQ_W-1:0]          sx_reg, sy_reg;
    logic [SQ_W-1:0]          sum_reg;

    logic signed [DIFF_W-1:0] dx_next, dy_next;
    logic                     wrap_x_next, wrap_y_next;
    logic signed [WRAP_W-1:0] wx_next, wy_next;
    logic [MAG_W-1:0]         mx_next, my_next;
    logic signed [WRAP_W-1:0] len_s, half_s, neg_half_s;
    logic signed [WRAP_W-1:0] ax, ay, nx, ny;

    always_comb
    begin
        dx_next     = DIFF_W'(first_x) - DIFF_W'(second_x);
        dy_next     = DIFF_W'(first_y) - DIFF_W'(second_y);
        wrap_x_next = 1'b0;
        wrap_y_next = 1'b0;
        case (func_t'(func))
            FUNC_BOTH:
            begin
                wrap_x_next = 1'b1;
                wrap_y_next = 1'b1;
            end
            FUNC_X_ONLY:
            begin
                wrap_x_next = 1'b1;
            end
            FUNC_ORIGIN:
            begin
                dx_next = DIFF_W'(first_x);
                dy_next = DIFF_W'(first_y);
            end
            default:
            begin
                wrap_x_next = 1'b0;
            end
        endcase
    end

    // Add or subtract the box length once when beyond half the box, on each axis whose wrap flag is set.
    always_comb
    begin
        len_s      = $signed({2'b00, box_length});
        half_s     = $signed({3'b000, box_length[BOX_W-1:1]});
        neg_half_s = -half_s;
        ax         = WRAP_W'(dx_reg);
        ay         = WRAP_W'(dy_reg);
        wx_next    = ax;
        wy_next    = ay;
        if (wrap_x_reg)
        begin
            if (ax < neg_half_s)
                wx_next = ax + len_s;
            else if (ax > half_s)
                wx_next = ax - len_s;
        end
        if (wrap_y_reg)
        begin
            if (ay < neg_half_s)
                wy_next = ay + len_s;
            else if (ay > half_s)
                wy_next = ay - len_s;
        end
    end

    always_comb
    begin
        nx      = wx_reg[WRAP_W-1] ? -wx_reg : wx_reg;
        ny      = wy_reg[WRAP_W-1] ? -wy_reg : wy_reg;
        mx_next = nx[MAG_W-1:0];
        my_next = ny[MAG_W-1:0];
    end

    always_comb
    begin
        valid_next = {valid_reg[3:0], load};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (en)
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg     <= dx_next;
            dy_reg     <= dy_next;
            wrap_x_reg <= wrap_x_next;
            wrap_y_reg <= wrap_y_next;
            wx_reg     <= wx_next;
            wy_reg     <= wy_next;
            mx_reg     <= mx_next;
            my_reg     <= my_next;
            sx_reg     <= mx_reg * mx_reg;
            sy_reg     <= my_reg * my_reg;
            sum_reg    <= sx_reg + sy_reg;
        end
    end

    assign slot.valid = valid_reg[4];
    assign slot.rad   = sum_reg;
    assign slot.rem   = '0;
    assign slot.root  = '0;

endmodule

// ===== design/pmid_sqrt_cell.sv =====
module pmid_sqrt_cell
    import pmid_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  sqrt_slot_t slot_in,
    output sqrt_slot_t slot_out
);

    logic              valid_reg;
    logic [SQ_W-1:0]   rad_reg,  rad_next;
    logic [REM_W-1:0]  rem_reg,  rem_next;
    logic [ROOT_W-1:0] root_reg, root_next;
    logic [REM_W+1:0]  rem_ext, trial, diff;
    logic              take;

    // One restoring step: bring down two radicand bits, try root*4+1.
    always_comb
    begin
        rem_ext   = {slot_in.rem, slot_in.rad[SQ_W-1 -: 2]};
        trial     = {1'b0, slot_in.root, 2'b01};
        diff      = rem_ext - trial;
        take      = (rem_ext >= trial);
        rem_next  = take ? diff[REM_W-1:0] : rem_ext[REM_W-1:0];
        root_next = {slot_in.root[ROOT_W-2:0], take};
        rad_next  = {slot_in.rad[SQ_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= slot_in.valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign slot_out.valid = valid_reg;
    assign slot_out.rad   = rad_reg;
    assign slot_out.rem   = rem_reg;
    assign slot_out.root  = root_reg;

endmodule

// ===== design/pmid_checker.sv =====
module pmid_checker
    import pmid_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [DIST_W-1:0]         dist_out,
    input logic                      cfg_valid,
    input logic                      cfg_ready
);

    // Hold a stalled result.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(dist_out))
        else $error("stalled result changed");

    // Input backpressure only comes from a stalled, full output register.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without output stall");

    // Root of a sum of two squares of 25-bit magnitudes stays below 2^25.
    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !dist_out[DIST_W-1])
        else $error("distance out of range");

    // Config writes always transfer.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("config write refused");

endmodule

bind periodic_min_image_distance_top pmid_checker u_pmid_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .dist_out  (dist_out),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready)
);
